/* rtl/core/pmd_pkg.sv */
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by pmd_front, pmd_queue, pmd_back and the top level.
package pmd_pkg;

  // Packet format codes held in the configuration register
  localparam logic [1:0] FMT_STD   = 2'd0;
  localparam logic [1:0] FMT_WHEEL = 2'd1;
  localparam logic [1:0] FMT_FIVE  = 2'd2;

  // Flag byte checks: bit 3 always one, overflow bits 7:6 must be clear
  localparam logic [7:0] FLAG_CHECK_MASK = 8'hC8;
  localparam logic [7:0] FLAG_ALWAYS_ONE = 8'h08;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One complete, accepted packet waiting for decode
  typedef struct packed {
    logic [1:0] fmt;
    logic [7:0] flags;
    logic [7:0] x_lo;
    logic [7:0] y_lo;
    logic [7:0] extra;
  } pmd_pkt_t;

  // Decoded result as it leaves on the output stream
  typedef struct packed {
    logic [7:0]        wheel;
    logic signed [9:0] delta_y;
    logic signed [8:0] delta_x;
    logic [4:0]        buttons;
  } pmd_res_t;

endpackage

/* rtl/core/pmd_front.sv */
// Byte assembler: groups mouse bytes into packets and drops bad ones.
// Depends on pmd_pkg; feeds the packet queue.
module pmd_front
  import pmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output pmd_pkt_t   pkt
);

  logic [1:0] fmt_r;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r [3];
  logic       len4;
  logic       last;
  logic       flags_ok;

  always_comb begin
    len4 = (fmt_r == FMT_WHEEL) || (fmt_r == FMT_FIVE);
    last = len4 ? (idx_r == 2'd3) : (idx_r >= 2'd2);
    pkt.fmt   = len4 ? fmt_r : FMT_STD;
    pkt.flags = byte_r[0];
    pkt.x_lo  = byte_r[1];
    // third byte may be arriving right now in standard format
    pkt.y_lo  = (idx_r == 2'd2) ? rx_byte : byte_r[2];
    pkt.extra = rx_byte;
    flags_ok  = (byte_r[0] & FLAG_CHECK_MASK) == FLAG_ALWAYS_ONE;
    push      = accept && last && flags_ok;
    idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_STD;
      idx_r <= 2'd0;
    end else begin
      if (cfg_valid) begin
        fmt_r <= cfg_data;
      end
      if (accept) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && idx_r != 2'd3) begin
      byte_r[idx_r] <= rx_byte;
    end
  end

endmodule

/* rtl/core/pmd_queue.sv */
// Short packet queue between the assembler and the decoder.
// Depends on pmd_pkg for the packet type.
module pmd_queue
  import pmd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pmd_pkt_t push_pkt,
  input  logic     pop,
  output pmd_pkt_t head_pkt,
  output logic     empty,
  output logic     full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  pmd_pkt_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == DEPTH_C);
  assign head_pkt = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

/* rtl/core/pmd_back.sv */
// Packet decoder: turns queued packets into buttons, deltas and wheel,
// held in an output register. Depends on pmd_pkg.
module pmd_back
  import pmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  pmd_pkt_t q_pkt,
  output logic     pop,
  input  logic     out_tready,
  output logic     out_tvalid,
  output pmd_res_t out_res
);

  logic     valid_r;
  pmd_res_t res_r, res_nxt;
  logic     five;

  always_comb begin
    five             = (q_pkt.fmt == FMT_FIVE);
    res_nxt.buttons  = {five & q_pkt.extra[5], five & q_pkt.extra[4], q_pkt.flags[2:0]};
    res_nxt.delta_x  = {q_pkt.flags[4], q_pkt.x_lo};
    // Y is negated so screen-down is positive
    res_nxt.delta_y  = 10'sd0 - $signed({{2{q_pkt.flags[5]}}, q_pkt.y_lo});
    unique case (q_pkt.fmt)
      FMT_WHEEL: res_nxt.wheel = q_pkt.extra;
      FMT_FIVE:  res_nxt.wheel = {{4{q_pkt.extra[3]}}, q_pkt.extra[3:0]};
      default:   res_nxt.wheel = 8'd0;
    endcase
    pop = !q_empty && (!valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

/* rtl/core/ps2_mouse_packet_decoder_unit.sv */
// PS/2 mouse packet decoder, top level.
// Uses pmd_pkg, pmd_front, pmd_queue and pmd_back.
//
// Usage:
//   in_*  : one mouse byte per item (in_tdata).
//   cfg_* : packet format write (0 standard, 1 wheel, 2 five-button);
//           always ready, write only while the block is idle.
//   out_* : one decoded packet per item.
// Bytes are taken one per cycle while the queue has room. A packet's
// last byte is assembled and checked in the cycle it arrives, queued,
// and then decoded from the queue head into the output register once
// that register is free or being drained. Throughput is one byte per
// cycle while the queue is not full. Packets with bad flag bits give
// no item.
// Reset clears the byte position and the queue, empties the output register and
// selects the standard format. When the receiver stalls, the held result
// stays put, the queue fills, and in_tready drops once it is full.
module ps2_mouse_packet_decoder_unit
  import pmd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,    // packet_format
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] buttons, [13:5] delta_x, [23:14] delta_y, [31:24] wheel
  output logic [31:0] out_tdata
);

  logic     accept;
  logic     push, pop, q_empty, q_full;
  pmd_pkt_t push_pkt, head_pkt;
  pmd_res_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign out_tdata = res;

  pmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .push      (push),
    .pkt       (push_pkt)
  );

  pmd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head_pkt (head_pkt),
    .empty    (q_empty),
    .full     (q_full)
  );

  pmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pkt      (head_pkt),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (res)
  );

endmodule

/* rtl/core/pmd_checker.sv */
// Port-level checks for the PS/2 mouse packet decoder top level.
// Bound to ps2_mouse_packet_decoder_unit; no package dependencies.
module pmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // an item appears on an empty output only after a byte was taken, whose
  // packet went through the queue into the output register
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a preceding byte");

  // negated 9-bit Y can never reach -256
  a_dy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:14] != 10'h300)
    else $error("delta_y out of range");

endmodule

bind ps2_mouse_packet_decoder_unit pmd_checker u_pmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
